[design/alpha_over_pixel_blend_defines.svh]
// ----------------------------------------------------------------------------
// alpha over pixel blend assertion macros
// shared concurrent assertion forms for the blend checker
// ----------------------------------------------------------------------------
`ifndef ALPHA_OVER_PIXEL_BLEND_DEFINES_SVH
`define ALPHA_OVER_PIXEL_BLEND_DEFINES_SVH

// same-cycle implication, masked while reset is asserted
`define AOP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aop assertion failed");

// next-cycle implication, masked while reset is asserted
`define AOP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aop assertion failed");

// next-cycle implication that also holds across reset
`define AOP_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("aop assertion failed");

`endif

[design/aop_pkg.sv]
// ----------------------------------------------------------------------------
// aop_pkg
// types, constants and rounding helper for the alpha over pixel blend
// ----------------------------------------------------------------------------
package aop_pkg;

  localparam int CH_BITS    = 8;
  localparam int PROD_BITS  = 2 * CH_BITS;
  localparam int NUM_COLORS = 3;

  typedef logic [CH_BITS-1:0]   chan_t;
  typedef logic [PROD_BITS-1:0] prod_t;

  localparam chan_t CH_MAX   = '1;
  localparam prod_t RND_HALF = prod_t'(1) << (CH_BITS - 1);

  typedef struct packed {
    chan_t back_red;
    chan_t back_green;
    chan_t back_blue;
    chan_t back_alpha;
    chan_t front_red;
    chan_t front_green;
    chan_t front_blue;
    chan_t front_alpha;
  } in_pixel_t;

  typedef struct packed {
    chan_t out_red;
    chan_t out_green;
    chan_t out_blue;
    chan_t out_alpha;
  } out_pixel_t;

  // pixel plus the special-case decisions made on entry
  typedef struct packed {
    in_pixel_t pix;
    logic      pass_front;
    logic      pass_back;
  } side_t;

  // one stage of the restoring divider
  typedef struct packed {
    chan_t rem;
    chan_t num_lo;
    chan_t quo;
    chan_t den;
    side_t side;
  } div_stage_t;

  // round(p / CH_MAX) for p up to CH_MAX * CH_MAX, no divider needed
  function automatic chan_t div_round_max(input prod_t p);
    prod_t t;
    prod_t u;
    t = p + RND_HALF;
    u = t + (t >> CH_BITS);
    return u[PROD_BITS-1:CH_BITS];
  endfunction

endpackage

[design/aop_div.sv]
// ----------------------------------------------------------------------------
// aop_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module aop_div (
  input  logic                    clk,
  input  logic [aop_pkg::CH_BITS-1:0] en,
  input  aop_pkg::div_stage_t     req,
  output aop_pkg::div_stage_t     rsp
);
  import aop_pkg::*;

  div_stage_t stg_r [CH_BITS];

  for (genvar k = 0; k < CH_BITS; k++) begin : g_stage
    div_stage_t         cur;
    div_stage_t         stg_nxt;
    logic [CH_BITS:0]   trial;
    logic [CH_BITS:0]   diff;
    logic               ge;

    if (k == 0) begin : g_first
      assign cur = req;
    end else begin : g_rest
      assign cur = stg_r[k-1];
    end

    always_comb begin
      trial = {cur.rem, cur.num_lo[CH_BITS-1]};
      diff  = trial - {1'b0, cur.den};
      ge    = (trial >= {1'b0, cur.den});
      stg_nxt        = cur;
      stg_nxt.rem    = ge ? diff[CH_BITS-1:0] : trial[CH_BITS-1:0];
      stg_nxt.num_lo = cur.num_lo << 1;
      stg_nxt.quo    = {cur.quo[CH_BITS-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        stg_r[k] <= stg_nxt;
      end
    end
  end

  assign rsp = stg_r[CH_BITS-1];

endmodule

[design/aop_lane.sv]
// ----------------------------------------------------------------------------
// aop_lane
// one colour lane: back + rounded (front - back) * scale / max
// ----------------------------------------------------------------------------
module aop_lane (
  input  logic           clk,
  input  logic           en,
  input  aop_pkg::chan_t back,
  input  aop_pkg::chan_t front,
  input  aop_pkg::chan_t scale,
  output aop_pkg::chan_t mix
);
  import aop_pkg::*;

  chan_t diff;
  logic  neg;
  prod_t prod_r;
  chan_t back_r;
  logic  neg_r;
  chan_t step;

  // magnitude and direction of the move from back toward front
  always_comb begin
    neg  = (front < back);
    diff = neg ? (back - front) : (front - back);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_t'(diff) * prod_t'(scale);
      back_r <= back;
      neg_r  <= neg;
    end
  end

  always_comb begin
    step = div_round_max(prod_r);
    mix  = neg_r ? (back_r - step) : (back_r + step);
  end

endmodule

[design/alpha_over_pixel_blend.sv]
// ----------------------------------------------------------------------------
// alpha_over_pixel_blend
// straight-alpha porter-duff over of a front rgba pixel onto a back pixel
// ----------------------------------------------------------------------------
// usage
//   in_valid/in_ready/in_data carry one back and one front pixel per transfer
//   out_valid/out_ready/out_data carry the composited pixel, one per input
//   the input passes stage a, stage b, the divider stages, the scale, lane and
//   output registers before out_valid; the divider gives one quotient bit per stage
//   throughput is one pixel per clock while out_ready stays high
//   the pipeline is elastic: each stage advances when the next one is empty
//   or advancing, so bubbles close up and inputs keep flowing while a
//   result waits at the output register
//   when the receiver stalls, the result holds and stages fill behind it;
//   in_ready drops only once every stage holds a pixel
//   synchronous reset (rst_n low) empties the pipeline; payload registers
//   are not cleared, only their valid flags
//   special cases (transparent back, identical opaque pixels, transparent
//   front) ride the same pipeline, so ordering and latency never change
// ----------------------------------------------------------------------------
module alpha_over_pixel_blend (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  aop_pkg::in_pixel_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output aop_pkg::out_pixel_t out_data
);
  import aop_pkg::*;

  // stage map
  localparam int ST_A       = 0;            // alpha product, case flags
  localparam int ST_B       = 1;            // result alpha, divider setup
  localparam int ST_DIV0    = 2;            // first divider stage
  localparam int ST_S       = ST_DIV0 + CH_BITS;  // scale rounding
  localparam int ST_L       = ST_S + 1;     // lane multiplies
  localparam int ST_OUT     = ST_L + 1;     // merge and output register
  localparam int NUM_STAGES = ST_OUT + 1;

  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] vld_nxt;
  logic [NUM_STAGES:0]   en;

  // ---------------------------------------------------------------------------
  // elastic pipeline control
  // ---------------------------------------------------------------------------
  assign en[NUM_STAGES] = out_ready;

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_ctl
    // a stage loads when it is empty or its content moves on
    assign en[k] = ~vld_r[k] | en[k+1];
    if (k == 0) begin : g_head
      assign vld_nxt[k] = en[k] ? in_valid : vld_r[k];
    end else begin : g_body
      assign vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = en[ST_A];
  assign out_valid = vld_r[ST_OUT];

  // ---------------------------------------------------------------------------
  // stage a: special-case flags and fa * ba
  // ---------------------------------------------------------------------------
  logic  same_pix;
  side_t a_side_nxt;
  side_t a_side_r;
  prod_t a_prod_r;

  always_comb begin
    same_pix = (in_data.back_red   == in_data.front_red)   &&
               (in_data.back_green == in_data.front_green) &&
               (in_data.back_blue  == in_data.front_blue)  &&
               (in_data.back_alpha == in_data.front_alpha);
    a_side_nxt.pix        = in_data;
    // identical pixels over an opaque back, or a fully transparent back
    a_side_nxt.pass_front = (same_pix && (in_data.back_alpha == CH_MAX)) ||
                            (in_data.back_alpha == '0);
    // fully transparent front leaves the back untouched
    a_side_nxt.pass_back  = !a_side_nxt.pass_front && (in_data.front_alpha == '0);
  end

  always_ff @(posedge clk) begin
    if (en[ST_A]) begin
      a_side_r <= a_side_nxt;
      a_prod_r <= prod_t'(in_data.front_alpha) * prod_t'(in_data.back_alpha);
    end
  end

  // ---------------------------------------------------------------------------
  // stage b: oa = fa + ba - round(fa * ba / max), numerator fa * max
  // ---------------------------------------------------------------------------
  logic [CH_BITS:0] alpha_sum;
  logic [CH_BITS:0] oa_full;
  prod_t            num;
  div_stage_t       b_div_nxt;
  div_stage_t       b_div_r;

  always_comb begin
    alpha_sum = {1'b0, a_side_r.pix.front_alpha} + {1'b0, a_side_r.pix.back_alpha};
    oa_full   = alpha_sum - {1'b0, div_round_max(a_prod_r)};
    // fa * max as a shift and a subtract
    num       = {a_side_r.pix.front_alpha, {CH_BITS{1'b0}}} -
                prod_t'(a_side_r.pix.front_alpha);
    b_div_nxt.rem    = num[PROD_BITS-1:CH_BITS];
    b_div_nxt.num_lo = num[CH_BITS-1:0];
    b_div_nxt.quo    = '0;
    b_div_nxt.den    = oa_full[CH_BITS-1:0];
    b_div_nxt.side   = a_side_r;
  end

  always_ff @(posedge clk) begin
    if (en[ST_B]) begin
      b_div_r <= b_div_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // divider: floor(fa * max / oa) with remainder
  // ---------------------------------------------------------------------------
  div_stage_t div_rsp;

  aop_div u_div (
    .clk (clk),
    .en  (en[ST_S-1:ST_DIV0]),
    .req (b_div_r),
    .rsp (div_rsp)
  );

  // ---------------------------------------------------------------------------
  // stage s: round the quotient to nearest
  // ---------------------------------------------------------------------------
  logic             rnd_up;
  logic [CH_BITS:0] scale_sum;
  chan_t            s_scale_r;
  chan_t            s_oa_r;
  side_t            s_side_r;

  always_comb begin
    rnd_up    = ({div_rsp.rem, 1'b0} >= {1'b0, div_rsp.den});
    scale_sum = {1'b0, div_rsp.quo} + (CH_BITS+1)'(rnd_up);
  end

  always_ff @(posedge clk) begin
    if (en[ST_S]) begin
      s_scale_r <= scale_sum[CH_BITS-1:0];
      s_oa_r    <= div_rsp.den;
      s_side_r  <= div_rsp.side;
    end
  end

  // ---------------------------------------------------------------------------
  // colour lanes: red, green, blue side by side
  // ---------------------------------------------------------------------------
  chan_t lane_back [NUM_COLORS];
  chan_t lane_front[NUM_COLORS];
  chan_t lane_mix  [NUM_COLORS];

  assign lane_back[0]  = s_side_r.pix.back_red;
  assign lane_back[1]  = s_side_r.pix.back_green;
  assign lane_back[2]  = s_side_r.pix.back_blue;
  assign lane_front[0] = s_side_r.pix.front_red;
  assign lane_front[1] = s_side_r.pix.front_green;
  assign lane_front[2] = s_side_r.pix.front_blue;

  for (genvar c = 0; c < NUM_COLORS; c++) begin : g_lane
    aop_lane u_lane (
      .clk   (clk),
      .en    (en[ST_L]),
      .back  (lane_back[c]),
      .front (lane_front[c]),
      .scale (s_scale_r),
      .mix   (lane_mix[c])
    );
  end

  // side data travels beside the lane registers
  chan_t l_oa_r;
  side_t l_side_r;

  always_ff @(posedge clk) begin
    if (en[ST_L]) begin
      l_oa_r   <= s_oa_r;
      l_side_r <= s_side_r;
    end
  end

  // ---------------------------------------------------------------------------
  // merge: pick pass-through or blended pixel into the output register
  // ---------------------------------------------------------------------------
  out_pixel_t out_nxt;
  out_pixel_t out_r;

  always_comb begin
    priority if (l_side_r.pass_front) begin
      out_nxt.out_red   = l_side_r.pix.front_red;
      out_nxt.out_green = l_side_r.pix.front_green;
      out_nxt.out_blue  = l_side_r.pix.front_blue;
      out_nxt.out_alpha = l_side_r.pix.front_alpha;
    end else if (l_side_r.pass_back) begin
      out_nxt.out_red   = l_side_r.pix.back_red;
      out_nxt.out_green = l_side_r.pix.back_green;
      out_nxt.out_blue  = l_side_r.pix.back_blue;
      out_nxt.out_alpha = l_side_r.pix.back_alpha;
    end else begin
      out_nxt.out_red   = lane_mix[0];
      out_nxt.out_green = lane_mix[1];
      out_nxt.out_blue  = lane_mix[2];
      out_nxt.out_alpha = l_oa_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

[design/aop_checker.sv]
// ----------------------------------------------------------------------------
// aop_checker
// port-level checks on the alpha over pixel blend, bound to the top level
// ----------------------------------------------------------------------------
`include "alpha_over_pixel_blend_defines.svh"

module aop_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input aop_pkg::out_pixel_t out_data
);

  // reset empties the pipeline
  `AOP_ASSERT_NEXT_ALWAYS(a_reset_empty, !rst_n, !out_valid)

  // with the output free the whole pipeline can move, so input is taken
  `AOP_ASSERT_NOW(a_ready_when_free, !out_valid || out_ready, in_ready)

  // a stalled result stays put until its transfer
  `AOP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind alpha_over_pixel_blend aop_checker u_aop_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: alpha over pixel blend testbench
// drives back/front rgba pairs through the blend pipeline under random
// sender and receiver stalls, predicts each composited pixel with an
// independent integer model of the straight-alpha over rule and checks
// every output transfer in order
// ----------------------------------------------------------------------------
module tb_top;
  import aop_pkg::*;

  // full-scale channel value, stands for 1.0
  localparam int unsigned FULL_SCALE   = (1 << CH_BITS) - 1;
  // base figure for the tail wait that follows
  localparam int          PIPE_LATENCY = CH_BITS + 4;
  localparam int          TAIL_CYCLES  = 3 * PIPE_LATENCY;
  // cycles with no transfer on either channel before giving up
  localparam int          STALL_LIMIT  = 4000;
  localparam int          RANDOM_ITEMS = 400;
  localparam int          MAX_SHOWN    = 10;

  // --------------------------------------------------------------------------
  // composited pixel predictor and in-order result store
  // --------------------------------------------------------------------------
  class blend_scoreboard;
    out_pixel_t  expected_q[$];
    int unsigned fail_count;
    int unsigned shown;

    // round to nearest, ties up
    static function int unsigned div_nearest(int unsigned num, int unsigned den);
      return (2 * num + den) / (2 * den);
    endfunction

    // move back toward front by s / full scale, both directions rounded on
    // the magnitude so the result never leaves the [back, front] span
    static function chan_t mix_channel(chan_t bk, chan_t fr, int unsigned s);
      int unsigned b;
      int unsigned f;
      b = bk;
      f = fr;
      if (f >= b) begin
        return chan_t'(b + div_nearest((f - b) * s, FULL_SCALE));
      end else begin
        return chan_t'(b - div_nearest((b - f) * s, FULL_SCALE));
      end
    endfunction

    static function out_pixel_t over_blend(in_pixel_t p);
      out_pixel_t  r;
      logic        same;
      int unsigned fa;
      int unsigned ba;
      int unsigned oa;
      int unsigned s;
      same = (p.back_red == p.front_red) && (p.back_green == p.front_green) &&
             (p.back_blue == p.front_blue) && (p.back_alpha == p.front_alpha);
      // identical pixels over an opaque back, or a fully transparent back:
      // front goes through untouched, alpha included
      if ((same && p.back_alpha == CH_MAX) || p.back_alpha == '0) begin
        r.out_red   = p.front_red;
        r.out_green = p.front_green;
        r.out_blue  = p.front_blue;
        r.out_alpha = p.front_alpha;
        return r;
      end
      // transparent front leaves the back pixel as it is
      if (p.front_alpha == '0) begin
        r.out_red   = p.back_red;
        r.out_green = p.back_green;
        r.out_blue  = p.back_blue;
        r.out_alpha = p.back_alpha;
        return r;
      end
      fa = p.front_alpha;
      ba = p.back_alpha;
      oa = fa + ba - div_nearest(fa * ba, FULL_SCALE);
      s  = div_nearest(fa * FULL_SCALE, oa);
      r.out_red   = mix_channel(p.back_red,   p.front_red,   s);
      r.out_green = mix_channel(p.back_green, p.front_green, s);
      r.out_blue  = mix_channel(p.back_blue,  p.front_blue,  s);
      r.out_alpha = chan_t'(oa);
      return r;
    endfunction

    function void note_input(in_pixel_t p);
      expected_q.push_back(over_blend(p));
    endfunction

    function void check_result(out_pixel_t got);
      out_pixel_t want;
      if (expected_q.size() == 0) begin
        fail_count++;
        if (shown < MAX_SHOWN) begin
          shown++;
          $display("unexpected result at %0t: r=%0d g=%0d b=%0d a=%0d", $time,
                   got.out_red, got.out_green, got.out_blue, got.out_alpha);
        end
        return;
      end
      want = expected_q.pop_front();
      if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
          got.out_blue !== want.out_blue || got.out_alpha !== want.out_alpha) begin
        fail_count++;
        if (shown < MAX_SHOWN) begin
          shown++;
          $display("mismatch at %0t: expected r=%0d g=%0d b=%0d a=%0d, got r=%0d g=%0d b=%0d a=%0d",
                   $time, want.out_red, want.out_green, want.out_blue, want.out_alpha,
                   got.out_red, got.out_green, got.out_blue, got.out_alpha);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and dut
  // --------------------------------------------------------------------------
  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  in_pixel_t  in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_pixel_t out_data;

  // stall rates in percent of cycles, changed per phase
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int          quiet_cycles  = 0;

  blend_scoreboard sb = new();

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  alpha_over_pixel_blend dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // --------------------------------------------------------------------------
  // receiver: ready drops at random, at the current phase's rate
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // --------------------------------------------------------------------------
  // monitor: every transfer is seen here with the values that were stable
  // before the edge; inputs feed the predictor, outputs are checked in order
  // the watchdog counts cycles in which neither channel moved
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_input(in_data);
      end
      if (out_valid && out_ready) begin
        sb.check_result(out_data);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic in_pixel_t make_pixel(int br, int bg, int bb, int ba,
                                           int fr, int fg, int fb, int fa);
    in_pixel_t p;
    p.back_red    = chan_t'(br);
    p.back_green  = chan_t'(bg);
    p.back_blue   = chan_t'(bb);
    p.back_alpha  = chan_t'(ba);
    p.front_red   = chan_t'(fr);
    p.front_green = chan_t'(fg);
    p.front_blue  = chan_t'(fb);
    p.front_alpha = chan_t'(fa);
    return p;
  endfunction

  // alpha biased toward the values that switch the special cases
  function automatic chan_t rand_alpha();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 12) return '0;
    if (r < 24) return CH_MAX;
    if (r < 30) return chan_t'(1);
    if (r < 34) return chan_t'(FULL_SCALE - 1);
    return chan_t'($urandom_range(FULL_SCALE));
  endfunction

  // colour mostly uniform, sometimes pinned to an end of the range
  function automatic chan_t rand_color();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return CH_MAX;
    return chan_t'($urandom_range(FULL_SCALE));
  endfunction

  function automatic in_pixel_t rand_pixel();
    in_pixel_t   p;
    int unsigned shape;
    p.back_red    = rand_color();
    p.back_green  = rand_color();
    p.back_blue   = rand_color();
    p.back_alpha  = rand_alpha();
    p.front_red   = rand_color();
    p.front_green = rand_color();
    p.front_blue  = rand_color();
    p.front_alpha = rand_alpha();
    shape = $urandom_range(99);
    if (shape < 8) begin
      // identical pixels, mostly over an opaque back
      p.front_red   = p.back_red;
      p.front_green = p.back_green;
      p.front_blue  = p.back_blue;
      if (shape < 6) p.back_alpha = CH_MAX;
      p.front_alpha = p.back_alpha;
    end else if (shape < 12) begin
      // same colour, different alpha
      p.front_red   = p.back_red;
      p.front_green = p.back_green;
      p.front_blue  = p.back_blue;
    end
    return p;
  endfunction

  // present one pixel; valid stays high after the transfer so back-to-back
  // items never see valid lowered and raised in the same step
  task automatic send_pixel(input in_pixel_t p);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (!in_ready);
  endtask

  // sender holds off until the pipeline has handed back every result
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_pixel(rand_pixel());
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // phase one: light sender stalls, heavy receiver stalls
    send_idle_pct = 16;
    recv_idle_pct = 72;

    // directed corners
    // everything zero (transparent back) and everything full (identical, opaque)
    send_pixel(make_pixel(0, 0, 0, 0, 0, 0, 0, 0));
    send_pixel(make_pixel(255, 255, 255, 255, 255, 255, 255, 255));
    // identical pixels over an opaque back pass the front
    send_pixel(make_pixel(17, 200, 93, 255, 17, 200, 93, 255));
    // identical but not opaque, goes through the full blend
    send_pixel(make_pixel(17, 200, 93, 254, 17, 200, 93, 254));
    // one colour differs with an opaque back: no shortcut
    send_pixel(make_pixel(17, 200, 93, 255, 18, 200, 93, 255));
    // transparent back with transparent, opaque and mid front
    send_pixel(make_pixel(255, 255, 255, 0, 12, 34, 56, 0));
    send_pixel(make_pixel(255, 0, 255, 0, 0, 255, 0, 255));
    send_pixel(make_pixel(90, 80, 70, 0, 1, 2, 3, 128));
    // transparent front leaves the back
    send_pixel(make_pixel(255, 128, 0, 255, 9, 9, 9, 0));
    send_pixel(make_pixel(3, 4, 5, 1, 250, 251, 252, 0));
    send_pixel(make_pixel(255, 255, 255, 255, 0, 0, 0, 0));
    // alpha extremes through the arithmetic path
    send_pixel(make_pixel(0, 0, 0, 255, 255, 255, 255, 255));
    send_pixel(make_pixel(255, 255, 255, 255, 0, 0, 0, 255));
    send_pixel(make_pixel(0, 255, 0, 1, 255, 0, 255, 1));
    send_pixel(make_pixel(0, 255, 0, 255, 255, 0, 255, 1));
    send_pixel(make_pixel(0, 255, 0, 1, 255, 0, 255, 255));
    send_pixel(make_pixel(0, 128, 255, 128, 255, 128, 0, 128));
    send_pixel(make_pixel(255, 200, 100, 200, 0, 50, 150, 128));
    send_pixel(make_pixel(1, 254, 127, 254, 254, 1, 128, 1));
    send_pixel(make_pixel(170, 85, 170, 85, 85, 170, 85, 170));

    send_random(RANDOM_ITEMS / 3);
    drain_pipeline();

    // phase two: the other way round
    send_idle_pct = 72;
    recv_idle_pct = 16;
    send_random(RANDOM_ITEMS / 3);
    drain_pipeline();

    // phase three: full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
    drain_pipeline();

    // any stray result after the drain is caught by the monitor
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
